/* rtl/aes_pkg.sv */
// Package for the AES-128 counter-mode stream block.
// Holds payload structs, the S-box function and round helpers; no dependencies.
package aes_pkg;

    localparam int RkDepth = 22;
    localparam int RkAw    = 4;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_IV_HIGH  = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_IV_LOW   = 2'd3;

    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  byte_count;
        logic        first_block;
    } in_item_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
        logic [4:0]  out_count;
        logic        counter_overflow;
    } out_item_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        begin
            unique case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // One cipher round without the key addition; byte 0 sits in bits 127:120.
    function automatic logic [127:0] round_fn(input logic [127:0] st, input logic last);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] o;
        begin
            for (int i = 0; i < 16; i++) s[i] = sbox(st[127-8*i -: 8]);
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) t[c*4+i] = s[((c+i)%4)*4+i];
            for (int c = 0; c < 4; c++) begin
                a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                if (!last) begin
                    t[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
                    t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
                    t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
                    t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
            return o;
        end
    endfunction

endpackage

/* rtl/aes128_ctr_stream.sv */
// Top level of the AES-128 counter-mode stream block.
// Uses aes_pkg and aes_keyexp; holds the round key memory and the round loop.
//
// One block is handled at a time. After acceptance it passes a step that
// primes the round key memory read, the initial key addition and ten
// rounds (one per cycle, paced by the registered round key memory read),
// and a step that forms the output once the output register is free.
// After reset and after each write to a key register the key schedule runs,
// during which no block is accepted.
module aes128_ctr_stream
    import aes_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_item_t            in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output out_item_t           out_item
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PRIME = 4'b0010,
        ST_ROUND = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [63:0]   key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic [127:0]  ctr_reg, ctr_next;
    logic          wrapped_reg, wrapped_next;
    logic [127:0]  st_reg, st_next;
    logic [3:0]    rnd_reg, rnd_next;
    in_item_t      item_reg;
    logic          refused_reg, refused_next;
    logic          ovalid_reg, ovalid_next;
    out_item_t     oitem_reg, oitem_next;

    logic [127:0]  rk_mem [RkDepth/2];
    logic [127:0]  rk_rd_reg;
    logic [RkAw-1:0] rd_addr;
    logic          kx_busy, kx_we;
    logic [RkAw-1:0] kx_addr;
    logic [127:0]  kx_data;
    logic          kx_start;
    logic          in_acc;
    logic [127:0]  data_w, ks_w, mask_w;
    logic [128:0]  ctr_inc;

    assign kx_start = cfg_we && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW);

    aes_keyexp u_keyexp (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (kx_start),
        .key     ({cfg_index == CFG_KEY_HIGH ? cfg_data : key_high_reg,
                   cfg_index == CFG_KEY_LOW  ? cfg_data : key_low_reg}),
        .busy    (kx_busy),
        .wr_en   (kx_we),
        .wr_addr (kx_addr),
        .wr_data (kx_data)
    );

    always_ff @(posedge clk)
    begin
        if (kx_we) rk_mem[kx_addr] <= kx_data;
        rk_rd_reg <= rk_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
            CFG_KEY_HIGH: key_high_reg <= cfg_data;
            CFG_KEY_LOW:  key_low_reg  <= cfg_data;
            CFG_IV_HIGH:  iv_high_reg  <= cfg_data;
            CFG_IV_LOW:   iv_low_reg   <= cfg_data;
            default: ;
            endcase
        end
    end

    assign in_ready = (state_reg == ST_IDLE) && !kx_busy;
    assign in_acc   = in_valid && in_ready;
    assign rd_addr  = (state_reg == ST_ROUND && rnd_reg != 4'd10) ?
                      RkAw'(rnd_reg + 4'd1) : '0;

    always_comb
    begin
        data_w  = {item_reg.data_high, item_reg.data_low};
        ks_w    = st_reg;
        for (int i = 0; i < 16; i++)
            mask_w[127-8*i -: 8] = (5'(i) < item_reg.byte_count) ? 8'hff : 8'h00;
        ctr_inc = {1'b0, ctr_reg} + 129'd1;
        state_next   = state_reg;
        ctr_next     = ctr_reg;
        wrapped_next = wrapped_reg;
        st_next      = st_reg;
        rnd_next     = rnd_reg;
        refused_next = refused_reg;
        ovalid_next  = ovalid_reg;
        oitem_next   = oitem_reg;
        if (ovalid_reg && out_ready) ovalid_next = 1'b0;
        unique case (state_reg)
        ST_IDLE:
        begin
            if (in_acc)
            begin
                if (in_item.first_block)
                begin
                    ctr_next     = {iv_high_reg, iv_low_reg};
                    wrapped_next = 1'b0;
                    refused_next = 1'b0;
                end
                else
                begin
                    refused_next = wrapped_reg;
                end
                state_next = ST_PRIME;
            end
        end
        ST_PRIME:
        begin
            st_next    = ctr_reg;
            rnd_next   = 4'd0;
            state_next = ST_ROUND;
        end
        ST_ROUND:
        begin
            // rk_rd_reg holds round key rnd_reg here.
            if (rnd_reg == 4'd0) st_next = st_reg ^ rk_rd_reg;
            else st_next = round_fn(st_reg, rnd_reg == 4'd10) ^ rk_rd_reg;
            rnd_next = rnd_reg + 4'd1;
            if (rnd_reg == 4'd10) state_next = ST_DONE;
        end
        ST_DONE:
        begin
            if (!ovalid_reg || out_ready)
            begin
                oitem_next.out_high         = refused_reg ? 64'h0 :
                                              64'(((data_w ^ ks_w) & mask_w) >> 64);
                oitem_next.out_low          = refused_reg ? 64'h0 : 64'(((data_w ^ ks_w) & mask_w));
                oitem_next.out_count        = item_reg.byte_count;
                oitem_next.counter_overflow = refused_reg;
                ovalid_next = 1'b1;
                if (!refused_reg)
                begin
                    ctr_next = ctr_inc[127:0];
                    if (ctr_inc[128]) wrapped_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
        end
        default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ctr_reg     <= '0;
            wrapped_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
            rnd_reg     <= 4'd0;
            refused_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ctr_reg     <= ctr_next;
            wrapped_reg <= wrapped_next;
            ovalid_reg  <= ovalid_next;
            rnd_reg     <= rnd_next;
            refused_reg <= refused_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg    <= st_next;
        oitem_reg <= oitem_next;
        if (in_acc) item_reg <= in_item;
    end

    assign out_valid = ovalid_reg;
    assign out_item  = oitem_reg;

`ifndef NO_ASSERTIONS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_no_key_during_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !kx_we) else $error("key schedule ran mid-block");
    a_prime_next: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PRIME |=> state_reg == ST_ROUND && rnd_reg == 4'd0)
        else $error("round loop did not start");
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) && oitem_reg.counter_overflow |->
        oitem_reg.out_high == 64'h0 && oitem_reg.out_low == 64'h0)
        else $error("refused transaction carries data");
`endif

endmodule

/* rtl/aes_keyexp.sv */
// Key schedule sequencer for the AES-128 counter-mode block.
// Expands one round key per cycle into the round key memory; uses aes_pkg.
module aes_keyexp
    import aes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [127:0]      key,
    output logic              busy,
    output logic              wr_en,
    output logic [RkAw-1:0]   wr_addr,
    output logic [127:0]      wr_data
);

    logic [127:0] rk_reg, rk_next;
    logic [3:0]   step_reg, step_next;
    logic [7:0]   rc_reg, rc_next;
    logic         busy_reg, busy_next;
    logic [31:0]  w0, w1, w2, w3, tw;

    always_comb
    begin
        tw = sub_word({rk_reg[23:0], rk_reg[31:24]}) ^ {rc_reg, 24'h0};
        w0 = rk_reg[127:96] ^ tw;
        w1 = rk_reg[95:64] ^ w0;
        w2 = rk_reg[63:32] ^ w1;
        w3 = rk_reg[31:0] ^ w2;
        rk_next = rk_reg;
        step_next = step_reg;
        rc_next = rc_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rk_next = key;
            step_next = 4'd0;
            rc_next = 8'h01;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rk_next = {w0, w1, w2, w3};
            rc_next = xtime(rc_reg);
            step_next = step_reg + 4'd1;
            if (step_reg == 4'd10) busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 4'd0;
            busy_reg <= 1'b1;
            rc_reg   <= 8'h01;
            rk_reg   <= '0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            rc_reg   <= rc_next;
            rk_reg   <= rk_next;
        end
    end

    assign busy    = busy_reg || start;
    assign wr_en   = busy_reg && !start;
    assign wr_addr = RkAw'(step_reg);
    assign wr_data = rk_reg;

`ifndef NO_ASSERTIONS
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= 4'd10) else $error("key step past last round");
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && step_reg == 4'd0) else $error("key expansion did not restart");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && step_reg == 4'd10 |=> !busy_reg)
        else $error("key expansion did not finish");
`endif

endmodule
